[rtl/core/ils_pkg.sv]
// ils_pkg: types, sizes and codes for the indexed list store.
// No dependencies; imported by the cell and the top level.
package ils_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int ACT_W    = 4;
  localparam int ST_W     = 2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [ACT_W-1:0] {
    ACT_READ   = 4'd0,
    ACT_WRITE  = 4'd1,
    ACT_INSERT = 4'd2,
    ACT_ERASE  = 4'd3,
    ACT_PUSH   = 4'd4,
    ACT_POP    = 4'd5,
    ACT_CLEAR  = 4'd6,
    ACT_RESIZE = 4'd7,
    ACT_ASSIGN = 4'd8
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                     go;
    action_t                  act;
    logic [IDX_W-1:0]         pos;
    logic [CNT_W-1:0]         cnt;
    logic [CNT_W-1:0]         nlen;
    logic signed [WORD_W-1:0] word;
  } cell_cmd_t;

endpackage

[rtl/core/ils_cell.sv]
// ils_cell: one element of the list; loads, holds or takes a neighbor's word.
// Depends on ils_pkg.
module ils_cell (
  input  logic                              clk,
  input  ils_pkg::cell_cmd_t                cmd,
  input  logic [ils_pkg::IDX_W-1:0]         idx,
  input  logic signed [ils_pkg::WORD_W-1:0] left_word,
  input  logic signed [ils_pkg::WORD_W-1:0] right_word,
  output logic signed [ils_pkg::WORD_W-1:0] word,
  output logic signed [ils_pkg::WORD_W-1:0] word_next
);
  import ils_pkg::*;

  logic [CNT_W-1:0] idx_c;
  logic             pos_hit;
  logic             above;
  logic             cnt_hit;
  logic             below_cnt;
  logic             below_len;

  assign idx_c     = CNT_W'(idx);
  assign pos_hit   = (idx == cmd.pos);
  assign above     = (idx > cmd.pos);
  assign cnt_hit   = (idx_c == cmd.cnt);
  assign below_cnt = (idx_c < cmd.cnt);
  assign below_len = (idx_c < cmd.nlen);

  always_comb begin
    word_next = word;
    if (cmd.go) begin
      case (cmd.act)
        ACT_WRITE: begin
          if (pos_hit) word_next = cmd.word;
        end
        ACT_INSERT: begin
          if (pos_hit) word_next = cmd.word;
          else if (above) word_next = left_word;
        end
        ACT_ERASE: begin
          if (pos_hit || above) word_next = right_word;
        end
        ACT_PUSH: begin
          if (cnt_hit) word_next = cmd.word;
        end
        ACT_RESIZE: begin
          if (!below_cnt && below_len) word_next = cmd.word;
        end
        ACT_ASSIGN: begin
          if (below_len) word_next = cmd.word;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

[rtl/core/indexed_list_store_unit.sv]
// indexed_list_store_unit: ordered list of signed words held in a chain of cells.
// Depends on ils_pkg and ils_cell.
// The result is registered and valid in the cycle after a request is accepted; throughput one request per cycle
// while results are taken, set by the registered shift/load of the cell chain.
// Reset: synchronous, clears the element count and the result valid flag;
// element words are not cleared.
module indexed_list_store_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ils_pkg::ACT_W-1:0]         action,
  input  logic [ils_pkg::IDX_W-1:0]         position,
  input  logic signed [ils_pkg::WORD_W-1:0] word_in,
  input  logic [ils_pkg::CNT_W-1:0]         new_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ils_pkg::ST_W-1:0]          status,
  output logic signed [ils_pkg::WORD_W-1:0] word_out,
  output logic signed [ils_pkg::WORD_W-1:0] front_word,
  output logic signed [ils_pkg::WORD_W-1:0] back_word,
  output logic [ils_pkg::CNT_W-1:0]         length,
  output logic                              is_empty
);
  import ils_pkg::*;

  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_next;
  action_t                  act;
  status_t                  st_next;
  logic                     in_range;
  logic                     accept;
  cell_cmd_t                cmd;
  logic signed [WORD_W-1:0] cell_word [CAPACITY];
  logic signed [WORD_W-1:0] cell_word_next [CAPACITY];
  logic signed [WORD_W-1:0] rd_word;
  logic signed [WORD_W-1:0] back_next;
  logic [CNT_W-1:0]         last_next;

  assign act      = action_t'(action);
  assign in_range = (CNT_W'(position) < cnt);
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    st_next  = ST_OK;
    cnt_next = cnt;
    case (act)
      ACT_READ, ACT_WRITE: begin
        if (!in_range) st_next = ST_INDEX;
      end
      ACT_INSERT: begin
        if (!in_range) st_next = ST_INDEX;
        else if (cnt >= CAP_CNT) st_next = ST_FULL;
        else cnt_next = cnt + CNT_W'(1);
      end
      ACT_ERASE: begin
        if (!in_range) st_next = ST_INDEX;
        else cnt_next = cnt - CNT_W'(1);
      end
      ACT_PUSH: begin
        if (cnt >= CAP_CNT) st_next = ST_FULL;
        else cnt_next = cnt + CNT_W'(1);
      end
      ACT_POP: begin
        if (cnt == '0) st_next = ST_INDEX;
        else cnt_next = cnt - CNT_W'(1);
      end
      ACT_CLEAR: begin
        cnt_next = '0;
      end
      ACT_RESIZE, ACT_ASSIGN: begin
        if (new_length > CAP_CNT) st_next = ST_FULL;
        else cnt_next = new_length;
      end
      default: begin
      end
    endcase
  end

  assign cmd.go   = accept && (st_next == ST_OK);
  assign cmd.act  = act;
  assign cmd.pos  = position;
  assign cmd.cnt  = cnt;
  assign cmd.nlen = new_length;
  assign cmd.word = word_in;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [WORD_W-1:0] left_w;
    logic signed [WORD_W-1:0] right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[k+1];
    end
    ils_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (IDX_W'(k)),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[k]),
      .word_next  (cell_word_next[k])
    );
  end

  assign last_next = cnt_next - CNT_W'(1);

  always_comb begin
    rd_word   = '0;
    back_next = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (IDX_W'(k) == position) rd_word = rd_word | cell_word[k];
      if (CNT_W'(k) == last_next) back_next = back_next | cell_word_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= st_next;
      word_out   <= (act == ACT_READ && in_range) ? rd_word : '0;
      front_word <= (cnt_next != '0) ? cell_word_next[0] : '0;
      back_word  <= back_next;
      length     <= cnt_next;
      is_empty   <= (cnt_next == '0);
    end
  end

endmodule

[rtl/core/ils_checker.sv]
// ils_checker: port-level checks for indexed_list_store_unit, bound to the top.
// Depends on ils_pkg.
module ils_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [ils_pkg::ST_W-1:0]          status,
  input logic signed [ils_pkg::WORD_W-1:0] front_word,
  input logic signed [ils_pkg::WORD_W-1:0] back_word,
  input logic [ils_pkg::CNT_W-1:0]         length,
  input logic                              is_empty
);
  import ils_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(length))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (length == '0)) && (length <= CAP_CNT))
    else $error("length and empty flag disagree");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> front_word == '0 && back_word == '0)
    else $error("front or back nonzero on empty list");

  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("request gave no result");

endmodule

bind indexed_list_store_unit ils_checker u_ils_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .front_word (front_word),
  .back_word  (back_word),
  .length     (length),
  .is_empty   (is_empty)
);

[dv/list_store_checker.sv]
// list_store_checker: watches the request and result channels of the indexed list store, keeps
// its own copy of the list, predicts every result and compares it field by field.
// Depends on ils_pkg; instantiated by testbench beside the block.
`timescale 1ns / 100ps

module list_store_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [ils_pkg::ACT_W-1:0]         action,
  input  logic [ils_pkg::IDX_W-1:0]         position,
  input  logic signed [ils_pkg::WORD_W-1:0] word_in,
  input  logic [ils_pkg::CNT_W-1:0]         new_length,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [ils_pkg::ST_W-1:0]          status,
  input  logic signed [ils_pkg::WORD_W-1:0] word_out,
  input  logic signed [ils_pkg::WORD_W-1:0] front_word,
  input  logic signed [ils_pkg::WORD_W-1:0] back_word,
  input  logic [ils_pkg::CNT_W-1:0]         length,
  input  logic                              is_empty,
  output int                                error_count,
  output int                                results_checked,
  output int                                index_rejects,
  output int                                capacity_rejects,
  output int                                outstanding,
  output int                                live_length
);
  import ils_pkg::*;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] word_out;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] back_word;
    logic [CNT_W-1:0]         length;
    logic                     is_empty;
  } list_result_t;

  logic signed [WORD_W-1:0] held_words [CAPACITY];
  int unsigned              held_count;
  list_result_t             expected_results [$];

  task automatic log_mismatch(input string msg);
    $display("%0t list_store_checker: %s", $time, msg);
    error_count++;
  endtask

  function automatic list_result_t apply_request(
    input logic [ACT_W-1:0]         act,
    input logic [IDX_W-1:0]         pos,
    input logic signed [WORD_W-1:0] word,
    input logic [CNT_W-1:0]         nlen
  );
    list_result_t r;
    int unsigned  i;
    logic         in_range;
    r = '0;
    r.status = ST_OK;
    in_range = (pos < held_count);
    case (act)
      ACT_READ: begin
        if (in_range) r.word_out = held_words[pos];
        else r.status = ST_INDEX;
      end
      ACT_WRITE: begin
        if (in_range) held_words[pos] = word;
        else r.status = ST_INDEX;
      end
      ACT_INSERT: begin
        if (!in_range) begin
          r.status = ST_INDEX;
        end else if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = held_count; i > pos; i--) held_words[i] = held_words[i-1];
          held_words[pos] = word;
          held_count++;
        end
      end
      ACT_ERASE: begin
        if (!in_range) begin
          r.status = ST_INDEX;
        end else begin
          for (i = pos; i + 1 < held_count; i++) held_words[i] = held_words[i+1];
          held_count--;
        end
      end
      ACT_PUSH: begin
        if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          held_words[held_count] = word;
          held_count++;
        end
      end
      ACT_POP: begin
        if (held_count == 0) r.status = ST_INDEX;
        else held_count--;
      end
      ACT_CLEAR: begin
        held_count = 0;
      end
      ACT_RESIZE: begin
        if (nlen > CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = held_count; i < nlen; i++) held_words[i] = word;
          held_count = nlen;
        end
      end
      ACT_ASSIGN: begin
        if (nlen > CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = 0; i < nlen; i++) held_words[i] = word;
          held_count = nlen;
        end
      end
      default: ;
    endcase
    if (held_count != 0) begin
      r.front_word = held_words[0];
      r.back_word  = held_words[held_count-1];
    end
    r.length   = CNT_W'(held_count);
    r.is_empty = (held_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      held_count = 0;
      expected_results.delete();
      error_count = 0;
      results_checked = 0;
      index_rejects = 0;
      capacity_rejects = 0;
      outstanding <= 0;
      live_length <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(),
                                apply_request(action, position, word_in, new_length));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          log_mismatch($sformatf("result with no request pending (status %0d, length %0d)",
                                 status, length));
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.status == ST_INDEX) index_rejects++;
          if (want.status == ST_FULL) capacity_rejects++;
          if (status !== want.status)
            log_mismatch($sformatf("result %0d status: expected %0d, got %0d",
                                   results_checked, want.status, status));
          if (word_out !== want.word_out)
            log_mismatch($sformatf("result %0d word_out: expected %h, got %h",
                                   results_checked, want.word_out, word_out));
          if (front_word !== want.front_word)
            log_mismatch($sformatf("result %0d front_word: expected %h, got %h",
                                   results_checked, want.front_word, front_word));
          if (back_word !== want.back_word)
            log_mismatch($sformatf("result %0d back_word: expected %h, got %h",
                                   results_checked, want.back_word, back_word));
          if (length !== want.length)
            log_mismatch($sformatf("result %0d length: expected %0d, got %0d",
                                   results_checked, want.length, length));
          if (is_empty !== want.is_empty)
            log_mismatch($sformatf("result %0d is_empty: expected %0d, got %0d",
                                   results_checked, want.is_empty, is_empty));
        end
      end
      outstanding <= expected_results.size();
      live_length <= held_count;
    end
  end

endmodule

[dv/testbench.sv]
// testbench: drives directed and random list requests into indexed_list_store_unit
// with random idling on both channels; list_store_checker predicts and compares.
// Depends on ils_pkg, indexed_list_store_unit and list_store_checker.
`timescale 1ns / 100ps

module testbench;
  import ils_pkg::*;

  localparam int RANDOM_REQUESTS = 1300;
  localparam int QUIET_TAIL      = 150;
  localparam int CYCLE_LIMIT     = 400000;
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 4'd9;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 4'd15;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [ACT_W-1:0]         action;
  logic [IDX_W-1:0]         position;
  logic signed [WORD_W-1:0] word_in;
  logic [CNT_W-1:0]         new_length;
  logic                     out_valid;
  logic                     out_ready;
  logic [ST_W-1:0]          status;
  logic signed [WORD_W-1:0] word_out;
  logic signed [WORD_W-1:0] front_word;
  logic signed [WORD_W-1:0] back_word;
  logic [CNT_W-1:0]         length;
  logic                     is_empty;

  int error_count;
  int results_checked;
  int index_rejects;
  int capacity_rejects;
  int outstanding;
  int live_length;
  int cycle_count = 0;
  int sent_count = 0;
  bit settle = 1'b0;

  always #4 clk = ~clk;

  indexed_list_store_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .position(position), .word_in(word_in), .new_length(new_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .word_out(word_out), .front_word(front_word),
    .back_word(back_word), .length(length), .is_empty(is_empty)
  );

  list_store_checker u_list_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .position(position), .word_in(word_in), .new_length(new_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .word_out(word_out), .front_word(front_word),
    .back_word(back_word), .length(length), .is_empty(is_empty),
    .error_count(error_count), .results_checked(results_checked),
    .index_rejects(index_rejects), .capacity_rejects(capacity_rejects),
    .outstanding(outstanding), .live_length(live_length)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests outstanding", cycle_count, outstanding);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // result side: ready runs with random stalls until the quiet tail
  initial begin
    out_ready <= 1'b0;
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!settle && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic send_request(
    input logic [ACT_W-1:0]         act,
    input logic [IDX_W-1:0]         pos,
    input logic signed [WORD_W-1:0] word,
    input logic [CNT_W-1:0]         nlen
  );
    in_valid   <= 1'b1;
    action     <= act;
    position   <= pos;
    word_in    <= word;
    new_length <= nlen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic rest_sender();
    if (!settle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      4: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int               k;
    int               roll;
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] nlen;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    action     <= ACT_READ;
    position   <= '0;
    word_in    <= '0;
    new_length <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty list rejects
    send_request(ACT_READ,   4'd0,  '0, '0);
    send_request(ACT_POP,    4'd0,  '0, '0);
    send_request(ACT_INSERT, 4'd0,  32'sd5, '0);
    send_request(ACT_ERASE,  4'd0,  '0, '0);
    send_request(ACT_WRITE,  4'd0,  32'sd7, '0);
    // build, edit and shrink
    send_request(ACT_PUSH,   4'd0,  32'sh7fffffff, '0);
    send_request(ACT_PUSH,   4'd0,  32'sh80000000, '0);
    send_request(ACT_READ,   4'd1,  '0, '0);
    send_request(ACT_INSERT, 4'd0,  -32'sd1, '0);
    send_request(ACT_WRITE,  4'd2,  32'sh5a5a5a5a, '0);
    send_request(ACT_READ,   4'd15, '0, '0);
    send_request(ACT_ERASE,  4'd1,  '0, '0);
    send_request(ACT_ERASE,  4'd1,  '0, '0);
    // full list, oversized lengths, unused actions and clear
    send_request(ACT_ASSIGN, 4'd0,  32'sh12345678, 5'd16);
    send_request(ACT_PUSH,   4'd0,  32'sd1, '0);
    send_request(ACT_INSERT, 4'd15, 32'sd2, '0);
    send_request(ACT_READ,   4'd15, '0, '0);
    send_request(ACT_RESIZE, 4'd0,  32'sd3, 5'd31);
    send_request(ACT_ASSIGN, 4'd0,  32'sd4, 5'd17);
    send_request(ACT_RESIZE, 4'd0,  32'sd9, 5'd3);
    send_request(ACT_RESIZE, 4'd0,  32'shfedcba98, 5'd16);
    send_request(ACT_UNUSED_LO, 4'd5, 32'sd6, 5'd4);
    send_request(ACT_UNUSED_HI, 4'd15, -32'sd1, 5'd31);
    send_request(ACT_CLEAR,  4'd0,  '0, '0);
    send_request(ACT_ASSIGN, 4'd0,  32'sd8, 5'd0);
    wait_drained();

    for (k = 0; k < RANDOM_REQUESTS; k++) begin
      settle = (k >= RANDOM_REQUESTS - QUIET_TAIL);
      roll = $urandom_range(0, 99);
      if (roll < 18) act = ACT_PUSH;
      else if (roll < 32) act = ACT_READ;
      else if (roll < 44) act = ACT_WRITE;
      else if (roll < 56) act = ACT_INSERT;
      else if (roll < 66) act = ACT_ERASE;
      else if (roll < 74) act = ACT_POP;
      else if (roll < 83) act = ACT_RESIZE;
      else if (roll < 90) act = ACT_ASSIGN;
      else if (roll < 94) act = ACT_CLEAR;
      else act = ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      if (live_length != 0 && $urandom_range(0, 9) != 0)
        pos = IDX_W'($urandom_range(0, live_length - 1));
      else
        pos = IDX_W'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) nlen = CNT_W'($urandom_range(17, 31));
      else nlen = CNT_W'($urandom_range(0, 16));
      send_request(act, pos, pick_word(), nlen);
      if (k % 400 == 200) wait_drained();
      else rest_sender();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("covered %0d requests over every action, with empty, full and out-of-range cases",
             sent_count);
    $display("%0d results checked: %0d index rejects, %0d capacity rejects",
             results_checked, index_rejects, capacity_rejects);
    if (error_count == 0 && outstanding == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
